/* rtl/emr_pkg.sv */
package emr_pkg;

  // Field and accumulator widths.
  localparam int unsigned E_W    = 24;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SUM_W  = 34;
  localparam int unsigned SQS_W  = 58;
  localparam int unsigned PROD_W = 2 * E_W;

  // Shared adder width covers n * sum_sq and sum * sum (both below 2**69).
  localparam int unsigned ALU_W  = 70;
  localparam int unsigned ROOT_W = ALU_W / 2;
  localparam int unsigned STEP_W = 6;

  localparam int unsigned MAX_PARTICLES = 1024;

  localparam logic [E_W-1:0] REST_ENERGY_RESET = E_W'(511);

endpackage

/* rtl/energy_mean_and_rms.sv */
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    total_energy_i, last_item_i
// output    out        out_valid_o / out_stall_i  mean_energy_o, rms_spread_o, set_size_o
// config    in         cfg_we_i                   cfg_wdata_i (rest energy)
//
// An item that is not last is accepted, squared and accumulated in turn.
// A last item then runs on one shared 70-bit add/subtract unit: the squared sum,
// count times square sum, one subtract, 35 square root steps and two 35-step
// divisions by the count, and finally the load of the result register.
// A new item is taken while a result waits; a stalled result holds back the next load, and the input with it.
// Reset sets the rest energy to 511 keV and clears count and both sums.
module energy_mean_and_rms (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [emr_pkg::E_W-1:0]   cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [emr_pkg::E_W-1:0]   total_energy_i,
  input  logic                      last_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [emr_pkg::E_W-1:0]   mean_energy_o,
  output logic [emr_pkg::E_W-1:0]   rms_spread_o,
  output logic [emr_pkg::CNT_W-1:0] set_size_o
);
  import emr_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_ACC  = 4'd2;
  localparam logic [3:0] ST_SS   = 4'd3;
  localparam logic [3:0] ST_NQ   = 4'd4;
  localparam logic [3:0] ST_SUB  = 4'd5;
  localparam logic [3:0] ST_SQRT = 4'd6;
  localparam logic [3:0] ST_DIVM = 4'd7;
  localparam logic [3:0] ST_DIVR = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [E_W-1:0]    rest_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQS_W-1:0]  sqs_q;
  logic              out_valid_q;

  logic [E_W-1:0]    kin_q;
  logic              last_q;
  logic [PROD_W-1:0] prod_q;
  logic [ALU_W-1:0]  a_q;
  logic [ALU_W-1:0]  p_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W-1:0] x_q;
  logic [CNT_W-1:0]  rm_q;
  logic [STEP_W-1:0] step_q;
  logic [E_W-1:0]    mean_q;
  logic [E_W-1:0]    rms_q;
  logic [E_W-1:0]    mean_out_q;
  logic [E_W-1:0]    rms_out_q;
  logic [CNT_W-1:0]  size_out_q;

  logic              in_accept;
  logic              step_last;
  logic [E_W:0]      kin_diff;
  logic [E_W-1:0]    kin;
  logic [ALU_W-1:0]  alu_a;
  logic [ALU_W-1:0]  alu_b;
  logic              alu_sub;
  logic [ALU_W:0]    alu_sum;
  logic              alu_ge;
  logic [ALU_W-1:0]  rem_sh;
  logic [ROOT_W-1:0] x_next;
  logic              out_free;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign mean_energy_o = mean_out_q;
  assign rms_spread_o  = rms_out_q;
  assign set_size_o    = size_out_q;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign step_last     = (step_q == '0);

  // Kinetic energy saturates to zero when the total is below the rest energy.
  assign kin_diff = {1'b0, total_energy_i} - {1'b0, rest_q};
  assign kin      = kin_diff[E_W] ? '0 : kin_diff[E_W-1:0];

  // The square root brings down two bits of the difference per step.
  assign rem_sh = {p_q[ALU_W-3:0], a_q[ALU_W-1 -: 2]};

  // Shared add/subtract unit; on a subtract the carry out means a >= b.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_SS: begin
        alu_a = {p_q[ALU_W-2:0], 1'b0};
        alu_b = sum_q[step_q] ? ALU_W'(sum_q) : '0;
      end
      ST_NQ: begin
        alu_a = {a_q[ALU_W-2:0], 1'b0};
        alu_b = cnt_q[step_q[3:0]] ? ALU_W'(sqs_q) : '0;
      end
      ST_SUB: begin
        alu_a   = a_q;
        alu_b   = p_q;
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = rem_sh;
        alu_b   = ALU_W'({root_q, 2'b01});
        alu_sub = 1'b1;
      end
      ST_DIVM, ST_DIVR: begin
        alu_a   = ALU_W'({rm_q, x_q[ROOT_W-1]});
        alu_b   = ALU_W'(cnt_q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b} + (ALU_W+1)'(alu_sub);
  assign alu_ge  = alu_sum[ALU_W];
  assign x_next  = {x_q[ROOT_W-2:0], alu_ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = last_q ? ST_SS : ST_IDLE;
      ST_SS:   if (step_last) state_d = ST_NQ;
      ST_NQ:   if (step_last) state_d = ST_SUB;
      ST_SUB:  state_d = ST_SQRT;
      ST_SQRT: if (step_last) state_d = ST_DIVM;
      ST_DIVM: if (step_last) state_d = ST_DIVR;
      ST_DIVR: if (step_last) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rest_q      <= REST_ENERGY_RESET;
      cnt_q       <= '0;
      sum_q       <= '0;
      sqs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rest_q <= cfg_wdata_i;
      end
      if (state_q == ST_ACC && cnt_q < CNT_W'(MAX_PARTICLES)) begin
        cnt_q <= cnt_q + CNT_W'(1);
        sum_q <= sum_q + SUM_W'(kin_q);
        sqs_q <= sqs_q + SQS_W'(prod_q);
      end else if (state_q == ST_OUT && out_free) begin
        cnt_q <= '0;
        sum_q <= '0;
        sqs_q <= '0;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kin_q  <= kin;
      last_q <= last_item_i;
    end
    case (state_q)
      ST_MUL: begin
        prod_q <= kin_q * kin_q;
      end
      ST_ACC: begin
        p_q    <= '0;
        step_q <= STEP_W'(SUM_W - 1);
      end
      ST_SS: begin
        p_q    <= alu_sum[ALU_W-1:0];
        step_q <= step_q - STEP_W'(1);
        if (step_last) begin
          a_q    <= '0;
          step_q <= STEP_W'(CNT_W - 1);
        end
      end
      ST_NQ: begin
        a_q    <= alu_sum[ALU_W-1:0];
        step_q <= step_q - STEP_W'(1);
      end
      ST_SUB: begin
        // A negative difference cannot arise, but it would report zero spread.
        a_q    <= alu_ge ? alu_sum[ALU_W-1:0] : '0;
        p_q    <= '0;
        root_q <= '0;
        step_q <= STEP_W'(ROOT_W - 1);
      end
      ST_SQRT: begin
        p_q    <= alu_ge ? alu_sum[ALU_W-1:0] : rem_sh;
        root_q <= {root_q[ROOT_W-2:0], alu_ge};
        a_q    <= {a_q[ALU_W-3:0], 2'b00};
        step_q <= step_q - STEP_W'(1);
        if (step_last) begin
          x_q    <= ROOT_W'(sum_q);
          rm_q   <= '0;
          step_q <= STEP_W'(ROOT_W - 1);
        end
      end
      ST_DIVM: begin
        x_q    <= x_next;
        rm_q   <= alu_ge ? alu_sum[CNT_W-1:0] : {rm_q[CNT_W-2:0], x_q[ROOT_W-1]};
        step_q <= step_q - STEP_W'(1);
        if (step_last) begin
          mean_q <= x_next[E_W-1:0];
          x_q    <= root_q;
          rm_q   <= '0;
          step_q <= STEP_W'(ROOT_W - 1);
        end
      end
      ST_DIVR: begin
        x_q    <= x_next;
        rm_q   <= alu_ge ? alu_sum[CNT_W-1:0] : {rm_q[CNT_W-2:0], x_q[ROOT_W-1]};
        step_q <= step_q - STEP_W'(1);
        if (step_last) begin
          rms_q <= x_next[E_W-1:0];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          mean_out_q <= mean_q;
          rms_out_q  <= rms_q;
          size_out_q <= cnt_q;
        end
      end
      default: begin
        step_q <= step_q;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PARTICLES))
    else $error("item count beyond the set limit");

  a_nonempty_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SS) |-> (cnt_q != '0))
    else $error("set closed with no items counted");

  a_sqrt_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (p_q[ALU_W-1:ROOT_W+2] == '0))
    else $error("square root remainder out of range");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result shown without a finished set");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && last_q) |=> (state_q == ST_SS))
    else $error("last item did not start the final computation");

endmodule
